FILE: sv/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg - shared types and constants of the bit field stream packer
// Operation codes, field widths and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int POS_W    = 24;  // bit position and capacity width
  localparam int WORD_W   = 32;  // packed word width
  localparam int VALUE_W  = 64;  // input value width
  localparam int NBITS_W  = 6;   // raw field width field
  localparam int OP_W     = 3;

  localparam logic [POS_W-1:0] CAP_RESET = POS_W'(16384);

  typedef enum logic [OP_W-1:0] {
    OP_RAW    = 3'd0,
    OP_VARCODE = 3'd1,
    OP_UVARINT = 3'd2,
    OP_ZVARINT = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take a new input beat
    logic step;  // commit the current piece
  } bfsp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;  // current piece produces an output beat
    logic last;  // current piece is the last of the item
    logic busy;  // output register holds a beat that is not taken this cycle
  } bfsp_stat_t;

endpackage

FILE: sv/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl - packer controller
// Accepts one input beat, then steps the datapath one piece per cycle,
// holding while a word must go out and the output register holds a beat not taken.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfsp_pkg::bfsp_stat_t stat,
  output bfsp_pkg::bfsp_cmd_t  cmd
);
  import bfsp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  logic   commit;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_RUN) && !(stat.emit && stat.busy);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_RUN;
        end
        S_RUN: begin
          if (commit && stat.last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/bfsp_dp.sv
// ----------------------------------------------------------------------------
// bfsp_dp - packer datapath
// Piece generator, bit accumulator with capacity check, output register.
// ----------------------------------------------------------------------------
module bfsp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfsp_pkg::POS_W-1:0]    cfg_data,
  input  logic [bfsp_pkg::OP_W-1:0]     op,
  input  logic [bfsp_pkg::VALUE_W-1:0]  value,
  input  logic [bfsp_pkg::NBITS_W-1:0]  nbits,
  input  bfsp_pkg::bfsp_cmd_t           cmd,
  output bfsp_pkg::bfsp_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfsp_pkg::WORD_W-1:0]   word,
  output logic [5:0]                    valid_bits,
  output logic [bfsp_pkg::POS_W-1:0]    total_bits,
  output logic                          overflowed,
  output logic                          last
);
  import bfsp_pkg::*;

  // item registers
  logic [OP_W-1:0]    op_r;
  logic [NBITS_W-1:0] nbits_r;
  logic [VALUE_W-1:0] d;
  logic               phase;

  // packer state
  logic [POS_W-1:0]  cap;
  logic [WORD_W-1:0] partial;
  logic [POS_W-1:0]  pos;
  logic              flag;

  // current piece
  logic [WORD_W-1:0] bits;
  logic [5:0]        n;
  logic              p_last;
  logic              is_flush;

  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   v;
  logic [2*WORD_W-1:0] comb;
  logic [4:0]          off;
  logic [6:0]          fill_sum;
  logic                fill;
  logic                over;
  logic                same_word;
  logic                ovf_emit;
  logic                emit;
  logic [POS_W-1:0]    left;
  logic [POS_W-1:0]    word_total;
  logic [WORD_W-1:0]   cap_mask;
  logic [VALUE_W-1:0]  zz;
  logic                big;

  assign zz  = {value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{value[VALUE_W-1]}};
  assign big = (d[VALUE_W-1:7] != '0);

  // piece generator
  always_comb begin
    bits     = '0;
    n        = '0;
    p_last   = 1'b1;
    is_flush = 1'b0;
    case (op_r)
      OP_RAW: begin
        bits = d[WORD_W-1:0];
        n    = (nbits_r > 6'd32) ? 6'd32 : nbits_r;
      end
      OP_VARCODE: begin
        if (phase) begin
          bits = {16'b0, d[31:16]};
          n    = 6'd16;
        end else if (d[31:4] == '0) begin
          bits = {26'b0, d[3:0], 2'b00};
          n    = 6'd6;
        end else if (d[31:8] == '0) begin
          bits = {22'b0, d[7:0], 2'b01};
          n    = 6'd10;
        end else if (d[31:12] == '0) begin
          bits = {18'b0, d[11:0], 2'b10};
          n    = 6'd14;
        end else begin
          bits   = {14'b0, d[15:0], 2'b11};
          n      = 6'd18;
          p_last = 1'b0;
        end
      end
      OP_UVARINT, OP_ZVARINT: begin
        bits   = {24'b0, big, d[6:0]};
        n      = 6'd8;
        p_last = !big;
      end
      OP_FLUSH: is_flush = 1'b1;
      default: ;  // unknown op: nothing
    endcase
  end

  // accumulator and capacity check
  assign off        = pos[4:0];
  assign mask       = WORD_W'((33'(1) << n) - 33'(1));
  assign v          = bits & mask;
  assign comb       = {32'b0, partial} | ({32'b0, v} << off);
  assign fill_sum   = {2'b0, off} + {1'b0, n};
  assign fill       = fill_sum >= 7'd32;
  assign left       = (pos >= cap) ? '0 : (cap - pos);
  assign over       = left < {{(POS_W-6){1'b0}}, n};
  assign same_word  = (cap[POS_W-1:5] == pos[POS_W-1:5]);
  assign ovf_emit   = !same_word && (cap > pos);
  assign word_total = {pos[POS_W-1:5] + (POS_W-5)'(1), 5'b0};
  assign cap_mask   = WORD_W'((33'(1) << cap[4:0]) - 33'(1));
  assign emit       = is_flush || ((n != '0) && (over ? ovf_emit : fill));

  assign stat.emit = emit;
  assign stat.last = p_last;
  assign stat.busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      nbits_r <= nbits;
      d       <= (op == OP_ZVARINT) ? zz : value;
      phase   <= 1'b0;
    end else if (cmd.step) begin
      phase <= 1'b1;
      // only varints consume the value seven bits at a time
      if (op_r == OP_UVARINT || op_r == OP_ZVARINT) d <= {7'b0, d[VALUE_W-1:7]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      partial   <= '0;
      pos       <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) cap <= cfg_data;

      if (cmd.step && emit) out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;

      // output fields only change when a committed piece emits a beat
      if (cmd.step) begin
        if (is_flush) begin
          word       <= partial;
          valid_bits <= {1'b0, pos[4:0]};
          total_bits <= pos;
          overflowed <= flag;
          last       <= 1'b1;
          partial    <= '0;
          pos        <= '0;
          flag       <= 1'b0;
        end else if (n != '0) begin
          if (over) begin
            // no room: jump to capacity, zero gap bits
            flag <= 1'b1;
            pos  <= cap;
            if (same_word) partial <= partial & cap_mask;
            else           partial <= '0;
            if (ovf_emit) begin
              word       <= partial;
              valid_bits <= 6'd32;
              total_bits <= word_total;
              overflowed <= 1'b1;
              last       <= 1'b0;
            end
          end else begin
            pos <= pos + {{(POS_W-6){1'b0}}, n};
            if (fill) begin
              word       <= comb[WORD_W-1:0];
              valid_bits <= 6'd32;
              total_bits <= word_total;
              overflowed <= flag;
              last       <= 1'b0;
              partial    <= comb[2*WORD_W-1:WORD_W];
            end else begin
              partial <= comb[WORD_W-1:0];
            end
          end
        end
      end
    end
  end

endmodule

FILE: sv/bit_field_stream_packer.sv
// ----------------------------------------------------------------------------
// bit_field_stream_packer - LSB-first bit packer into 32-bit words
// Raw fields, prefixed variable codes, LEB128 and zigzag varints, flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, value, nbits per beat.
//   Output channel (out_valid/out_ready) carries one packed word per beat
//   with valid_bits, total_bits, the sticky overflowed flag and last.
//   An item yields zero to three output beats; flush always yields one
//   with last set and restarts the message at bit 0.
//   cfg_we/cfg_data write capacity_bits (reset 16384); write only while idle.
// Sequencing:
//   The item is loaded, then the datapath accumulator takes one piece per
//   cycle while no stall holds it: raw field, short variable code, flush or
//   unknown op 1 piece; 32-bit variable code 2; varint 1 to 10 byte pieces.
//   The next input is accepted only after the item's last piece commits.
//   An output beat is registered as its piece commits, valid the next cycle.
// Stalls:
//   The output register holds one word; a piece that completes a word waits
//   while that register is full and not being taken. Input waits meanwhile.
// Reset:
//   Synchronous rst clears position, partial word, overflow flag and the
//   output valid flag, and restores the capacity to 16384.
// ----------------------------------------------------------------------------
module bit_field_stream_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfsp_pkg::POS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfsp_pkg::OP_W-1:0]     op,
  input  logic [bfsp_pkg::VALUE_W-1:0]  value,
  input  logic [bfsp_pkg::NBITS_W-1:0]  nbits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfsp_pkg::WORD_W-1:0]   word,
  output logic [5:0]                    valid_bits,
  output logic [bfsp_pkg::POS_W-1:0]    total_bits,
  output logic                          overflowed,
  output logic                          last
);
  import bfsp_pkg::*;

  bfsp_cmd_t  cmd;
  bfsp_stat_t stat;

  // sequencing: load, then one piece per cycle unless the output stalls
  bfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // piece generation, packing and output beat register
  bfsp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .op         (op),
    .value      (value),
    .nbits      (nbits),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .valid_bits (valid_bits),
    .total_bits (total_bits),
    .overflowed (overflowed),
    .last       (last)
  );

endmodule

FILE: tb/tb_bit_field_stream_packer.sv
// ----------------------------------------------------------------------------
// tb_bit_field_stream_packer - self-checking bench for the bit packer
// A directed table (extremes, every op, overflow jumps, flush) followed by
// random phases at several capacities. Both channels idle at random; each output
// beat is checked field by field against an in-bench packer model or a table row.
// ----------------------------------------------------------------------------
module tb_bit_field_stream_packer;

  import bfsp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 24;   // longer than the longest item plus the output stage
  localparam int HOLD_AT_BEAT  = 60;   // receiver stops taking beats here once
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_BEATS     = 3;    // most words one item can produce
  localparam int PHASES        = 9;
  localparam int ITEMS_PER_PH  = 34;

  // ops 5..7 are unused codes: the block must swallow them silently
  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

  // variable code size classes
  localparam logic [31:0] VC_4BIT_LIMIT  = 32'h10;
  localparam logic [31:0] VC_8BIT_LIMIT  = 32'h100;
  localparam logic [31:0] VC_12BIT_LIMIT = 32'h1000;
  localparam logic [1:0]  VC_PFX_4  = 2'd0;
  localparam logic [1:0]  VC_PFX_8  = 2'd1;
  localparam logic [1:0]  VC_PFX_12 = 2'd2;
  localparam logic [1:0]  VC_PFX_32 = 2'd3;

  localparam logic [63:0] LEB_LOW7 = 64'h7F;
  localparam logic [63:0] ONES     = '1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [5:0]        valid_bits;
    logic [POS_W-1:0]  total_bits;
    logic              overflowed;
    logic              last;
  } packed_beat_t;

  localparam packed_beat_t NO_BEAT = '0;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table; for ROW_CFG the capacity sits in value
  typedef struct packed {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [VALUE_W-1:0] value;
    logic [NBITS_W-1:0] nbits;
    bit                typed;  // want holds the one beat this row must give
    packed_beat_t      want;
  } plan_row_t;

  localparam int PLAN_ROWS = 35;

  plan_row_t plan [PLAN_ROWS] = '{
    // flush straight out of reset: empty message
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'h0, 6'd0, 24'd0, 1'b0, 1'b1}},
    // full-width raw field fills exactly one word
    '{ROW_ITEM, OP_RAW,     ONES, 6'd32, 1'b1, '{32'hFFFF_FFFF, 6'd32, 24'd32, 1'b0, 1'b0}},
    // flush on a word boundary: no content bits left
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'h0, 6'd0, 24'd32, 1'b0, 1'b1}},
    // width above 32 saturates
    '{ROW_ITEM, OP_RAW,     64'h0123_4567_89AB_CDEF, 6'd63, 1'b0, NO_BEAT},
    // every variable code class, the 32-bit form at both ends
    '{ROW_ITEM, OP_VARCODE, 64'h0F, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_VARCODE, 64'hFF, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_VARCODE, 64'hFFF, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_VARCODE, 64'hFFFF_FFFF_0000_1000, 6'd7, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_VARCODE, 64'hFFFF_FFFF, 6'd0, 1'b0, NO_BEAT},
    // varints: one byte, two bytes, ten bytes
    '{ROW_ITEM, OP_UVARINT, 64'h0, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_UVARINT, 64'h80, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_UVARINT, ONES, 6'd63, 1'b0, NO_BEAT},
    // zigzag: -1, most negative, most positive
    '{ROW_ITEM, OP_ZVARINT, ONES, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_ZVARINT, 64'h8000_0000_0000_0000, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_ZVARINT, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, NO_BEAT},
    // unused op: nothing out
    '{ROW_ITEM, OP_RESERVED_LO, ONES, 6'd32, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b0, NO_BEAT},
    // capacity dropped below the position: jump back, nothing emitted;
    // a zero-width field past capacity stays a no-op
    '{ROW_ITEM, OP_RAW,     ONES, 6'd32, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd8, 1'b0, NO_BEAT},
    '{ROW_CFG,  OP_RAW,     64'd10, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd1, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'h0, 6'd10, 24'd10, 1'b1, 1'b1}},
    // overflow into a later word: old word goes out zero padded
    '{ROW_CFG,  OP_RAW,     64'd40, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd30, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd20, 1'b1, '{32'h3FFF_FFFF, 6'd32, 24'd32, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd4, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'h0, 6'd8, 24'd40, 1'b1, 1'b1}},
    // overflow inside the same word: bits above capacity cleared
    '{ROW_CFG,  OP_RAW,     64'd20, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     64'hFF, 6'd8, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd16, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'hFF, 6'd20, 24'd20, 1'b1, 1'b1}},
    // zero capacity: every piece overflows
    '{ROW_CFG,  OP_RAW,     64'd0, 6'd0, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_RAW,     ONES, 6'd1, 1'b0, NO_BEAT},
    '{ROW_ITEM, OP_FLUSH,   64'h0, 6'd0, 1'b1, '{32'h0, 6'd0, 24'd0, 1'b1, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // DUT hookup; every input known from time 0
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [POS_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op        = '0;
  logic [VALUE_W-1:0]  value     = '0;
  logic [NBITS_W-1:0]  nbits     = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   word;
  logic [5:0]          valid_bits;
  logic [POS_W-1:0]    total_bits;
  logic                overflowed;
  logic                last;

  bit_field_stream_packer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .value      (value),
    .nbits      (nbits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .valid_bits (valid_bits),
    .total_bits (total_bits),
    .overflowed (overflowed),
    .last       (last)
  );

  always #10 clk = ~clk;

  int cycle_count = 0;
  int mismatches  = 0;
  int beats_taken = 0;

  // --------------------------------------------------------------------------
  // Packer model: capacity, partial word, bit position, sticky overflow.
  // Beats it produces go into beats_due, oldest first.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]  cap_model  = CAP_RESET;
  logic [WORD_W-1:0] acc_word   = '0;
  logic [POS_W-1:0]  bit_pos    = '0;
  logic              sticky_ovf = 1'b0;
  int                item_beats;
  packed_beat_t      beats_due[$];

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               beats_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void queue_beat(logic [WORD_W-1:0] w, logic [5:0] vb,
                                     logic [POS_W-1:0] tot, logic lst);
    if (item_beats >= MAX_BEATS) return;
    beats_due.push_back('{w, vb, tot, sticky_ovf, lst});
    item_beats++;
  endfunction

  function automatic void pack_piece(logic [31:0] bits, int unsigned width);
    int unsigned       left;
    int unsigned       off;
    logic [18:0]       old_wd;
    logic [18:0]       new_wd;
    logic [63:0]       v;
    logic [63:0]       comb;
    if (width == 0) return;
    if (width > 32) width = 32;
    left = (bit_pos >= cap_model) ? 0 : cap_model - bit_pos;

    if (left < width) begin
      // piece does not fit: jump to capacity, nothing written
      sticky_ovf = 1'b1;
      old_wd = bit_pos[POS_W-1:5];
      new_wd = cap_model[POS_W-1:5];
      if (new_wd != old_wd) begin
        // forward jump flushes the old word; backward jump emits nothing
        if (cap_model > bit_pos) queue_beat(acc_word, 6'd32, {old_wd + 19'd1, 5'd0}, 1'b0);
        acc_word = '0;
      end else begin
        acc_word &= (32'd1 << cap_model[4:0]) - 32'd1;
      end
      bit_pos = cap_model;
      return;
    end

    off  = bit_pos[4:0];
    v    = {32'd0, bits} & ((64'd1 << width) - 64'd1);
    comb = {32'd0, acc_word} | (v << off);
    bit_pos = bit_pos + POS_W'(width);
    if (off + width >= 32) begin
      queue_beat(comb[31:0], 6'd32, bit_pos - POS_W'(off + width - 32), 1'b0);
      acc_word = comb[63:32];
    end else begin
      acc_word = comb[31:0];
    end
  endfunction

  function automatic void pack_varint(logic [63:0] d);
    while (d > LEB_LOW7) begin
      pack_piece({24'd0, 1'b1, d[6:0]}, 8);
      d = d >> 7;
    end
    pack_piece({25'd0, d[6:0]}, 8);
  endfunction

  function automatic void pack_varcode(logic [31:0] d);
    if (d < VC_4BIT_LIMIT)       pack_piece({d[29:0], VC_PFX_4}, 6);
    else if (d < VC_8BIT_LIMIT)  pack_piece({d[29:0], VC_PFX_8}, 10);
    else if (d < VC_12BIT_LIMIT) pack_piece({d[29:0], VC_PFX_12}, 14);
    else begin
      pack_piece({d[29:0], VC_PFX_32}, 18);
      pack_piece({16'd0, d[31:16]}, 16);
    end
  endfunction

  function automatic void predict_item(logic [OP_W-1:0] op_code, logic [63:0] data,
                                       logic [NBITS_W-1:0] width);
    item_beats = 0;
    case (op_code)
      OP_RAW:     pack_piece(data[31:0], (width > 32) ? 32 : width);
      OP_VARCODE: pack_varcode(data[31:0]);
      OP_UVARINT: pack_varint(data);
      OP_ZVARINT: pack_varint((data << 1) ^ {64{data[63]}});
      OP_FLUSH: begin
        queue_beat(acc_word, {1'b0, bit_pos[4:0]}, bit_pos, 1'b1);
        acc_word   = '0;
        bit_pos    = '0;
        sticky_ovf = 1'b0;
      end
      default: ;  // unused codes do nothing
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("mismatch at beat %0d (cycle %0d): %s", beats_taken, cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_beat();
    packed_beat_t want;
    if (beats_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat word=%h last=%b", word, last));
      return;
    end
    want = beats_due.pop_front();
    if (word !== want.word)
      flag_mismatch($sformatf("word %h, want %h", word, want.word));
    if (valid_bits !== want.valid_bits)
      flag_mismatch($sformatf("valid_bits %0d, want %0d", valid_bits, want.valid_bits));
    if (total_bits !== want.total_bits)
      flag_mismatch($sformatf("total_bits %0d, want %0d", total_bits, want.total_bits));
    if (overflowed !== want.overflowed)
      flag_mismatch($sformatf("overflowed %b, want %b", overflowed, want.overflowed));
    if (last !== want.last)
      flag_mismatch($sformatf("last %b, want %b", last, want.last));
  endtask

  // --------------------------------------------------------------------------
  // Sender side helpers
  // --------------------------------------------------------------------------
  // Drive one item and return at the edge that accepts it. Valid is only
  // dropped when a gap follows, so back-to-back items keep it high.
  task automatic offer_item(logic [OP_W-1:0] op_code, logic [63:0] data,
                            logic [NBITS_W-1:0] width, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_code;
    value    <= data;
    nbits    <= width;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending, wait for every due beat, then let the last item (which may
  // give no beat) work its way through before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [POS_W-1:0] cap);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_model = cap;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall per beat, a stall-free stretch every third block
  // of 30 beats, and one long hold so the output stage backs up the input.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int stall;
    bit held;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && beats_taken == HOLD_AT_BEAT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if ((beats_taken / 30) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_beat();
      beats_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random phases at varied capacities
  // --------------------------------------------------------------------------
  initial begin : tx_side
    int               row;
    int               ph;
    int               k;
    int               pick;
    int               gap;
    int               depth;
    logic [OP_W-1:0]  o;
    logic [63:0]      v;
    logic [NBITS_W-1:0] n;
    logic [POS_W-1:0] caps [PHASES];

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].kind == ROW_CFG) begin
        settle();
        write_capacity(plan[row].value[POS_W-1:0]);
      end else begin
        offer_item(plan[row].op, plan[row].value, plan[row].nbits, $urandom_range(0, 10));
        depth = beats_due.size();
        predict_item(plan[row].op, plan[row].value, plan[row].nbits);
        // hand-written rows replace what the model queued
        if (plan[row].typed) begin
          while (beats_due.size() > depth) void'(beats_due.pop_back());
          beats_due.push_back(plan[row].want);
        end
      end
    end

    // extremes and small capacities where overflow is frequent, then reset and random
    caps[0] = '1;
    caps[1] = POS_W'(1);
    caps[2] = POS_W'(33);
    caps[3] = POS_W'($urandom_range(40, 700));
    caps[4] = '0;
    caps[5] = POS_W'($urandom_range(64, 2000));
    caps[6] = POS_W'($urandom_range(40, 400));
    caps[7] = CAP_RESET;
    caps[8] = POS_W'($urandom);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_capacity(caps[ph]);
      for (k = 0; k < ITEMS_PER_PH; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      o = OP_RAW;
        else if (pick < 55) o = OP_VARCODE;
        else if (pick < 70) o = OP_UVARINT;
        else if (pick < 85) o = OP_ZVARINT;
        else if (pick < 93) o = OP_FLUSH;
        else                o = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));

        // mostly short magnitudes so every varint length and code class shows up
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0) v = ~v;
        n = ($urandom_range(0, 7) == 0) ? NBITS_W'($urandom_range(33, 63))
                                        : NBITS_W'($urandom_range(0, 32));

        // phases 2 and 6 run the sender flat out
        gap = (ph == 2 || ph == 6) ? 0 : $urandom_range(0, 10);
        if (ph == 4 && k == 17) settle();  // sender pauses until all beats are out

        offer_item(o, v, n, gap);
        predict_item(o, v, n);
      end
    end

    settle();

    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: bit_field_stream_packer.f
sv/bfsp_pkg.sv
sv/bfsp_ctrl.sv
sv/bfsp_dp.sv
sv/bit_field_stream_packer.sv
tb/tb_bit_field_stream_packer.sv
